/* sv/jsu_pkg.sv */
// jsu_pkg: types, codes and decode functions for the JSON string unescaper.
// Used by jsu_front, jsu_fifo, jsu_back and json_string_unescape_utf8.
// No dependencies.
`default_nettype none

package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX0,
    MODE_HEX1,
    MODE_HEX2,
    MODE_HEX3
  } jsu_mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_CLOSED,
    KIND_BADESC,
    KIND_UNTERM
  } jsu_kind_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  // One queued command: up to three result items from one input item.
  typedef struct packed {
    logic [1:0] n;
    jsu_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } jsu_cmd_t;

  // {valid, digit}
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // {valid, byte}
  function automatic logic [8:0] escape_map(logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      8'h62:     r = {1'b1, 8'h08};
      8'h66:     r = {1'b1, 8'h0C};
      8'h6E:     r = {1'b1, 8'h0A};
      8'h72:     r = {1'b1, 8'h0D};
      8'h74:     r = {1'b1, 8'h09};
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic jsu_cmd_t single_cmd(logic [7:0] b, jsu_kind_t k);
    jsu_cmd_t c;
    c      = '0;
    c.n    = 2'd1;
    c.kind = k;
    c.b0   = b;
    return c;
  endfunction

  function automatic jsu_cmd_t utf8_cmd(logic [15:0] cp);
    jsu_cmd_t c;
    c      = '0;
    c.kind = KIND_BYTE;
    if (cp[15:7] == '0) begin
      c.n  = 2'd1;
      c.b0 = cp[7:0];
    end else if (cp[15:11] == '0) begin
      c.n  = 2'd2;
      c.b0 = 8'hC0 | {3'b000, cp[10:6]};
      c.b1 = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      c.n  = 2'd3;
      c.b0 = 8'hE0 | {4'b0000, cp[15:12]};
      c.b1 = 8'h80 | {2'b00, cp[11:6]};
      c.b2 = 8'h80 | {2'b00, cp[5:0]};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/jsu_front.sv */
// jsu_front: accepts input bytes, tracks escape/hex mode, builds commands.
// Depends on jsu_pkg.
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_buffer,
  input  wire logic       q_full,
  output logic            push,
  output jsu_cmd_t        cmd
);

  jsu_mode_t   mode, mode_next;
  logic [15:0] hex_value, hex_value_next;
  logic        hex_stopped, hex_stopped_next;
  logic        accept;
  logic [4:0]  hd;
  logic [8:0]  em;
  logic [15:0] hv_step;
  logic        hs_step;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign hd       = hex_digit(in_byte);
  assign em       = escape_map(in_byte);
  assign hv_step  = (!hex_stopped && hd[4]) ? {hex_value[11:0], hd[3:0]} : hex_value;
  assign hs_step  = hex_stopped || !hd[4];
  assign push     = accept && (cmd.n != 2'd0);

  always_comb begin
    mode_next        = mode;
    hex_value_next   = hex_value;
    hex_stopped_next = hex_stopped;
    unique case (mode)
      MODE_ESCAPE: begin
        if (!end_of_buffer && in_byte == CH_U) begin
          mode_next        = MODE_HEX0;
          hex_value_next   = '0;
          hex_stopped_next = 1'b0;
        end else if (!end_of_buffer && em[8]) begin
          mode_next = MODE_NORMAL;
        end else begin
          mode_next        = MODE_NORMAL;
          hex_value_next   = '0;
          hex_stopped_next = 1'b0;
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
        if (end_of_buffer) begin
          mode_next        = MODE_NORMAL;
          hex_value_next   = '0;
          hex_stopped_next = 1'b0;
        end else begin
          mode_next        = jsu_mode_t'(mode + 3'd1);
          hex_value_next   = hv_step;
          hex_stopped_next = hs_step;
        end
      end
      MODE_HEX3: begin
        mode_next        = MODE_NORMAL;
        hex_value_next   = '0;
        hex_stopped_next = 1'b0;
      end
      default: begin
        if (end_of_buffer || in_byte == CH_QUOTE) begin
          mode_next        = MODE_NORMAL;
          hex_value_next   = '0;
          hex_stopped_next = 1'b0;
        end else if (in_byte == CH_BSLASH) begin
          mode_next = MODE_ESCAPE;
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (mode)
      MODE_ESCAPE: begin
        if (end_of_buffer) begin
          cmd = single_cmd(8'h00, KIND_BADESC);
        end else if (in_byte == CH_U) begin
          cmd = '0;
        end else if (em[8]) begin
          cmd = single_cmd(em[7:0], KIND_BYTE);
        end else begin
          cmd = single_cmd(8'h00, KIND_BADESC);
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2: begin
        if (end_of_buffer) begin
          cmd = single_cmd(8'h00, KIND_UNTERM);
        end
      end
      MODE_HEX3: begin
        if (end_of_buffer) begin
          cmd = single_cmd(8'h00, KIND_UNTERM);
        end else begin
          cmd = utf8_cmd(hv_step);
        end
      end
      default: begin
        if (end_of_buffer) begin
          cmd = single_cmd(8'h00, KIND_UNTERM);
        end else if (in_byte == CH_QUOTE) begin
          cmd = single_cmd(8'h00, KIND_CLOSED);
        end else if (in_byte != CH_BSLASH) begin
          cmd = single_cmd(in_byte, KIND_BYTE);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      hex_value   <= '0;
      hex_stopped <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      hex_value   <= hex_value_next;
      hex_stopped <= hex_stopped_next;
    end
  end

endmodule

`default_nettype wire

/* sv/jsu_fifo.sv */
// jsu_fifo: short command queue between front and back.
// Depends on jsu_pkg.
`default_nettype none

module jsu_fifo import jsu_pkg::*; #(
  parameter int Depth = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire jsu_cmd_t  push_cmd,
  input  wire logic      pop,
  output jsu_cmd_t       head,
  output logic           full,
  output logic           empty,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  jsu_cmd_t        mem [Depth];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic            do_pop;

  assign full   = (count == CW'(Depth));
  assign empty  = (count == '0);
  assign head   = mem[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/jsu_back.sv */
// jsu_back: walks the head command and drives the registered output items.
// Depends on jsu_pkg.
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire jsu_cmd_t  head,
  input  wire logic      empty,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output logic [7:0]     out_byte,
  output logic [1:0]     kind,
  output logic           last
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;
  logic [7:0] sel;

  assign load    = (!out_valid || !out_stall) && !empty;
  assign is_last = (idx == head.n - 2'd1);
  assign pop     = load && is_last;

  always_comb begin
    unique case (idx)
      2'd0:    sel = head.b0;
      2'd1:    sel = head.b1;
      default: sel = head.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 2'd0 : idx + 2'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel;
      kind     <= head.kind;
      last     <= is_last;
    end
  end

endmodule

`default_nettype wire

/* sv/json_string_unescape_utf8.sv */
// json_string_unescape_utf8: top level, front -> command queue -> back.
// Depends on jsu_pkg, jsu_front, jsu_fifo, jsu_back.
//
//   channel | signals                         | direction
//   in      | in_valid in_stall in_byte       | into block
//           | end_of_buffer                   |
//   out     | out_valid out_stall out_byte    | out of block
//           | kind last                       |
//
// One input item is taken per cycle while the command queue has room.
// Results leave at one per cycle from the output register while out_stall is low; a \u escape
// that encodes to two or three bytes leaves as that many results from one queued command.
// in_stall rises only when the queue (QueueDepth commands) is full.
// Reset is synchronous on rst and returns the decoder to normal mode.
`default_nettype none

module json_string_unescape_utf8 import jsu_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_buffer,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic            last
);

  localparam int CW = $clog2(QueueDepth + 1);

  jsu_cmd_t      push_cmd;
  jsu_cmd_t      head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic [CW-1:0] q_count;

  jsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_buffer (end_of_buffer),
    .q_full        (q_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QueueDepth))
    else $error("command queue over depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_full))
    else $error("push into full queue");

  a_multi_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> (out_valid && kind == KIND_BYTE))
    else $error("multi-byte sequence broken");

  a_nonlast_is_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (kind == KIND_BYTE))
    else $error("non-final result is not a byte");
`endif

endmodule

`default_nettype wire

/* tb/json_string_unescape_utf8_test.sv */
// Self-checking testbench for json_string_unescape_utf8: directed table, then random
// string bodies, escapes, \u sequences and noise, checked against a decoder model in the bench.
// Depends on jsu_pkg and the json_string_unescape_utf8 RTL.
module json_string_unescape_utf8_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam int PERIOD      = 20;
  localparam int RAND_ITEMS  = 400;
  localparam int CALM_ITEMS  = 60;
  localparam int DRAIN_AT    = 250;
  localparam int HOLD_AT     = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;

  localparam logic [7:0] ESC_LETTER [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
                                           8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       typed;
    logic [7:0] xb;
    jsu_kind_t  xk;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] ob;
    jsu_kind_t  k;
    logic       lst;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_buffer = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  stim_row_t   stim_q[$];
  stim_row_t   offered = '0;
  dec_result_t step_res[$];
  dec_result_t decoded_q[$];
  int          errors = 0;
  int          n_got = 0;
  bit          calm = 1'b0;

  jsu_mode_t   dec_mode;
  logic [15:0] dec_cp;
  logic        dec_cp_done;

  // Directed items; typed rows carry their single expected result.
  stim_row_t directed [24] = '{
    '{8'h41,     1'b0, 1'b1, 8'h41, KIND_BYTE},
    '{8'h00,     1'b0, 1'b1, 8'h00, KIND_BYTE},
    '{8'hFF,     1'b0, 1'b1, 8'hFF, KIND_BYTE},
    '{CH_QUOTE,  1'b0, 1'b1, 8'h00, KIND_CLOSED},
    '{8'hFF,     1'b1, 1'b1, 8'h00, KIND_UNTERM},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h71,     1'b0, 1'b1, 8'h00, KIND_BADESC},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h00,     1'b1, 1'b1, 8'h00, KIND_BADESC},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h44,     1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h38,     1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h30,     1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h30,     1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h37,     1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h66,     1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h66,     1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{CH_QUOTE,  1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{CH_BSLASH, 1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{CH_U,      1'b0, 1'b0, 8'h00, KIND_BYTE},
    '{8'h31,     1'b1, 1'b1, 8'h00, KIND_UNTERM}
  };

  json_string_unescape_utf8 dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_buffer(end_of_buffer),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .kind         (kind),
    .last         (last)
  );

  always #(PERIOD / 2) clk = ~clk;

  task automatic flag_error(input string msg);
    errors++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // ---------------- decoder model ----------------

  function automatic logic [4:0] hex_val(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic [8:0] esc_val(logic [7:0] c);
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: return {1'b1, c};
      8'h62:   return 9'h108;
      8'h66:   return 9'h10C;
      8'h6E:   return 9'h10A;
      8'h72:   return 9'h10D;
      8'h74:   return 9'h109;
      default: return 9'h000;
    endcase
  endfunction

  function void reset_decoder();
    dec_mode    = MODE_NORMAL;
    dec_cp      = 16'h0000;
    dec_cp_done = 1'b0;
  endfunction

  function void add_res(logic [7:0] b, jsu_kind_t k);
    step_res.push_back('{b, k, 1'b0});
  endfunction

  function void decode_step(logic [7:0] b, logic e);
    logic [4:0] h;
    logic [8:0] x;
    step_res.delete();
    h = hex_val(b);
    x = esc_val(b);
    case (dec_mode)
      MODE_ESCAPE: begin
        if (e) begin
          add_res(8'h00, KIND_BADESC);
          reset_decoder();
        end else if (b == CH_U) begin
          dec_mode    = MODE_HEX0;
          dec_cp      = 16'h0000;
          dec_cp_done = 1'b0;
        end else if (x[8]) begin
          add_res(x[7:0], KIND_BYTE);
          dec_mode = MODE_NORMAL;
        end else begin
          add_res(8'h00, KIND_BADESC);
          reset_decoder();
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (e) begin
          add_res(8'h00, KIND_UNTERM);
          reset_decoder();
        end else begin
          if (!dec_cp_done && h[4]) dec_cp = {dec_cp[11:0], h[3:0]};
          else dec_cp_done = 1'b1;
          if (dec_mode == MODE_HEX3) begin
            if (dec_cp < 16'd128) begin
              add_res(dec_cp[7:0], KIND_BYTE);
            end else if (dec_cp < 16'd2048) begin
              add_res(8'hC0 | {3'b000, dec_cp[10:6]}, KIND_BYTE);
              add_res(8'h80 | {2'b00, dec_cp[5:0]}, KIND_BYTE);
            end else begin
              add_res(8'hE0 | {4'b0000, dec_cp[15:12]}, KIND_BYTE);
              add_res(8'h80 | {2'b00, dec_cp[11:6]}, KIND_BYTE);
              add_res(8'h80 | {2'b00, dec_cp[5:0]}, KIND_BYTE);
            end
            reset_decoder();
          end else begin
            dec_mode = jsu_mode_t'(dec_mode + 3'd1);
          end
        end
      end
      default: begin
        if (e) begin
          add_res(8'h00, KIND_UNTERM);
          reset_decoder();
        end else if (b == CH_QUOTE) begin
          add_res(8'h00, KIND_CLOSED);
          reset_decoder();
        end else if (b == CH_BSLASH) begin
          dec_mode = MODE_ESCAPE;
        end else begin
          add_res(b, KIND_BYTE);
          dec_mode = MODE_NORMAL;
        end
      end
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].lst = 1'b1;
  endfunction

  // ---------------- stimulus generation ----------------

  task automatic add_item(input logic [7:0] b, input logic e);
    stim_row_t r;
    r = '{b, e, 1'b0, 8'h00, KIND_BYTE};
    stim_q.push_back(r);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    case ($urandom_range(0, 3))
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  task automatic add_unicode();
    logic [15:0] cp;
    int cls;
    cls = $urandom_range(0, 2);
    cp  = 16'($urandom);
    if (cls == 0) cp = cp & 16'h007F;
    else if (cls == 1) cp = cp & 16'h07FF;
    add_item(CH_BSLASH, 1'b0);
    add_item(CH_U, 1'b0);
    for (int k = 3; k >= 0; k--) begin
      if ($urandom_range(0, 9) == 0) add_item(non_hex(), 1'b0);
      else add_item(hex_char(cp[4*k +: 4]), 1'b0);
    end
  endtask

  task automatic add_string();
    int len;
    logic [7:0] b;
    len = $urandom_range(0, 8);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          b = 8'($urandom);
          if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
          add_item(b, 1'b0);
        end
        5, 6: begin
          add_item(CH_BSLASH, 1'b0);
          add_item(ESC_LETTER[$urandom_range(0, 7)], 1'b0);
        end
        default: add_unicode();
      endcase
    end
    if ($urandom_range(0, 9) != 0) add_item(CH_QUOTE, 1'b0);
    else add_item(8'($urandom), 1'b1);
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 3))
      0: begin
        add_item(CH_BSLASH, 1'b0);
        add_item(8'($urandom), 1'b0);
      end
      1: begin
        add_item(CH_BSLASH, 1'b0);
        add_item(8'($urandom), 1'b1);
      end
      2: begin
        add_item(CH_BSLASH, 1'b0);
        add_item(CH_U, 1'b0);
        repeat ($urandom_range(0, 3)) add_item(hex_char(4'($urandom)), 1'b0);
        add_item(8'($urandom), 1'b1);
      end
      default: begin
        repeat ($urandom_range(1, 6)) add_item(8'($urandom), $urandom_range(0, 7) == 0);
      end
    endcase
  endtask

  // ---------------- monitors ----------------

  always @(posedge clk) begin
    if (rst) begin
      reset_decoder();
    end else if (in_valid && !in_stall) begin
      decode_step(in_byte, end_of_buffer);
      if (offered.typed) begin
        decoded_q.push_back('{offered.xb, offered.xk, 1'b1});
      end else begin
        foreach (step_res[k]) decoded_q.push_back(step_res[k]);
      end
    end
  end

  always @(posedge clk) begin
    dec_result_t w;
    if (!rst && out_valid && !out_stall) begin
      n_got++;
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("unexpected result byte %02h kind %0d last %0d",
                             out_byte, kind, last));
      end else begin
        w = decoded_q.pop_front();
        if (out_byte !== w.ob)
          flag_error($sformatf("result %0d: byte %02h, want %02h", n_got, out_byte, w.ob));
        if (kind !== w.k)
          flag_error($sformatf("result %0d: kind %0d, want %0d", n_got, kind, w.k));
        if (last !== w.lst)
          flag_error($sformatf("result %0d: last %0d, want %0d", n_got, last, w.lst));
      end
    end
  end

  // ---------------- receiver ----------------

  initial begin
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && n_got >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (calm ? 1 : $urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  // ---------------- sender ----------------

  initial begin
    foreach (directed[k]) stim_q.push_back(directed[k]);
    while (stim_q.size() < $size(directed) + RAND_ITEMS) begin
      if ($urandom_range(0, 4) != 0) add_string();
      else add_noise();
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == stim_q.size() - CALM_ITEMS) calm = 1'b1;
      if (i == DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_byte       <= stim_q[i].b;
      end_of_buffer <= stim_q[i].e;
      offered       <= stim_q[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) flag_error("results still outstanding at end of run");

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_fifo.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_test.sv
